@@ rtl/aglh_pkg.sv @@
// Shared constants and types for the alignment gap length histogram.
package aglh_pkg;

   localparam int MAX_GAP    = 10;
   localparam int CHAR_W     = 8;
   localparam int BIN_W      = 4;
   localparam int RUN_W      = 4;
   localparam int COUNT_W    = 32;
   localparam int HIST_IDX_W = (MAX_GAP > 1) ? $clog2(MAX_GAP) : 1;

   localparam logic [CHAR_W-1:0] GAP_CHAR = 8'h2D;  // '-'

   typedef enum logic [0:0] {
      FUNC_COLUMN  = 1'b0,
      FUNC_READOUT = 1'b1
   } func_type;

   // one request item as held in the input register
   typedef struct packed {
      logic [0:0]        func;
      logic [CHAR_W-1:0] ref_char;
      logic [CHAR_W-1:0] read_char;
      logic              last_column;
      logic [BIN_W-1:0]  bin_select;
   } req_item_type;

   // command from the top level to one string tracker
   typedef struct packed {
      logic             en;
      logic             readout;
      logic             is_gap;
      logic             last;
      logic [BIN_W-1:0] sel;
   } track_cmd_type;

   // what one tracker reports for the current item
   typedef struct packed {
      logic               done;
      logic [BIN_W-1:0]   bin;
      logic [COUNT_W-1:0] count;
   } track_res_type;

endpackage

@@ rtl/aglh_req_if.sv @@
// Request channel: valid/ready handshake with the column or readout item.
interface aglh_req_if import aglh_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [0:0]        func;
   logic [CHAR_W-1:0] ref_char;
   logic [CHAR_W-1:0] read_char;
   logic              last_column;
   logic [BIN_W-1:0]  bin_select;

   modport source (output valid, func, ref_char, read_char, last_column, bin_select,
                   input ready);
   modport sink (input valid, func, ref_char, read_char, last_column, bin_select,
                 output ready);
endinterface

@@ rtl/aglh_rsp_if.sv @@
// Response channel: valid/ready handshake with the gap and count result item.
interface aglh_rsp_if import aglh_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               ref_gap_done;
   logic [BIN_W-1:0]   ref_gap_bin;
   logic               read_gap_done;
   logic [BIN_W-1:0]   read_gap_bin;
   logic [COUNT_W-1:0] ref_bin_count;
   logic [COUNT_W-1:0] read_bin_count;

   modport source (output valid, ref_gap_done, ref_gap_bin, read_gap_done, read_gap_bin,
                   ref_bin_count, read_bin_count,
                   input ready);
   modport sink (input valid, ref_gap_done, ref_gap_bin, read_gap_done, read_gap_bin,
                 ref_bin_count, read_bin_count,
                 output ready);
endinterface

@@ rtl/alignment_gap_length_histogram.sv @@
// Top level of the alignment gap length histogram.
// Each request item is either an alignment column (func 0: one reference
// character, one read character and a last-column flag) or a readout (func 1:
// bin_select picks a bin). For the reference and the read string separately
// the block measures runs of '-' and, when a base closes a run that began
// after an earlier base of the same read, counts it in bin
// min(length, MAX_GAP) - 1 (MAX_GAP = 10); the response then carries the done
// flag, the bin and the updated count. Runs before the first base of a read or
// still open at the last column are dropped. Counts saturate at 0xFFFFFFFF and
// are cleared by reset; a readout of a bin at or above MAX_GAP returns zeros.
// Every request yields exactly one response. An item first sits in the input
// register, where the run counters and histograms are updated as it moves on,
// and then sits in the response register, which drives rsp valid. The block
// takes one item per cycle while the response side does not stall; the limit
// is the single read-increment-write of each histogram per item. Ready only
// drops when both registers are full and the response side stalls.
module alignment_gap_length_histogram import aglh_pkg::*; (
   input logic      clock,
   input logic      reset,
   aglh_req_if.sink   req_if,
   aglh_rsp_if.source rsp_if
);

   // input register
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   track_res_type rsp_ref_ff, rsp_read_ff;

   logic          accept;
   logic          advance;
   func_type      s1_func;
   logic          is_readout;
   track_cmd_type ref_cmd, read_cmd;
   track_res_type ref_res, read_res;

   // the input stage moves on whenever the response register is free or drains
   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;
   assign accept      = req_if.valid && req_if.ready;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_if.ready);

   assign s1_func = func_type'(s1_item_ff.func);

   always_comb begin
      unique case (s1_func)
         FUNC_COLUMN:  is_readout = 1'b0;
         FUNC_READOUT: is_readout = 1'b1;
         default:      is_readout = 1'b0;
      endcase
   end

   // both trackers see the same item; only the character differs
   always_comb begin
      ref_cmd.en      = advance;
      ref_cmd.readout = is_readout;
      ref_cmd.is_gap  = (s1_item_ff.ref_char == GAP_CHAR);
      ref_cmd.last    = s1_item_ff.last_column;
      ref_cmd.sel     = s1_item_ff.bin_select;

      read_cmd        = ref_cmd;
      read_cmd.is_gap = (s1_item_ff.read_char == GAP_CHAR);
   end

   aglh_gap_track u_ref_track (
      .clock (clock),
      .reset (reset),
      .cmd   (ref_cmd),
      .res   (ref_res)
   );

   aglh_gap_track u_read_track (
      .clock (clock),
      .reset (reset),
      .cmd   (read_cmd),
      .res   (read_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         s1_item_ff.func        <= req_if.func;
         s1_item_ff.ref_char    <= req_if.ref_char;
         s1_item_ff.read_char   <= req_if.read_char;
         s1_item_ff.last_column <= req_if.last_column;
         s1_item_ff.bin_select  <= req_if.bin_select;
      end
      if (advance) begin
         rsp_ref_ff  <= ref_res;
         rsp_read_ff <= read_res;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.ref_gap_done   = rsp_ref_ff.done;
   assign rsp_if.ref_gap_bin    = rsp_ref_ff.bin;
   assign rsp_if.read_gap_done  = rsp_read_ff.done;
   assign rsp_if.read_gap_bin   = rsp_read_ff.bin;
   assign rsp_if.ref_bin_count  = rsp_ref_ff.count;
   assign rsp_if.read_bin_count = rsp_read_ff.count;

   // an accepted item always lands in the input register
   assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item lost");

   // a readout never reports a counted run
   assert property (@(posedge clock) disable iff (reset)
      advance && is_readout |=> !rsp_ref_ff.done && !rsp_read_ff.done)
      else $error("readout reported a gap run");

   // bin fields stay zero unless a run was counted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ref_ff.done && !rsp_read_ff.done
      |-> rsp_ref_ff.bin == '0 && rsp_read_ff.bin == '0)
      else $error("bin set without a counted run");

   // a full input register with a free response register always moves on
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("input stage stuck");

endmodule

@@ rtl/aglh_gap_track.sv @@
// Gap run tracker for one string: run length, seen-base flag and histogram.
module aglh_gap_track import aglh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  track_cmd_type cmd,
   output track_res_type res
);

   logic [RUN_W-1:0]   run_ff, run_in;
   logic               seen_ff, seen_in;
   logic [COUNT_W-1:0] hist_ff [MAX_GAP];

   logic                  close_run;
   logic [BIN_W-1:0]      run_bin;
   logic                  sel_ok;
   logic [HIST_IDX_W-1:0] rd_idx;
   logic [COUNT_W-1:0]    rd_count;
   logic [COUNT_W-1:0]    inc_count;

   assign close_run = cmd.en && !cmd.readout && !cmd.is_gap
                      && (run_ff != '0) && seen_ff;
   assign run_bin   = BIN_W'(run_ff - RUN_W'(1));
   assign sel_ok    = (cmd.sel < BIN_W'(MAX_GAP));
   assign rd_idx    = cmd.readout ? cmd.sel[HIST_IDX_W-1:0] : run_bin[HIST_IDX_W-1:0];
   // guard out-of-range readout indices before they reach the array
   assign rd_count  = (cmd.readout && !sel_ok) ? '0 : hist_ff[rd_idx];
   assign inc_count = (rd_count == '1) ? rd_count : rd_count + COUNT_W'(1);

   always_comb begin
      res.done  = close_run;
      res.bin   = close_run ? run_bin : '0;
      if (cmd.readout) begin
         res.count = rd_count;
      end else if (close_run) begin
         res.count = inc_count;
      end else begin
         res.count = '0;
      end
   end

   always_comb begin
      run_in  = run_ff;
      seen_in = seen_ff;
      if (cmd.en && !cmd.readout) begin
         if (cmd.is_gap) begin
            if (run_ff < RUN_W'(MAX_GAP)) begin
               run_in = run_ff + RUN_W'(1);
            end
         end else begin
            run_in  = '0;
            seen_in = 1'b1;
         end
         if (cmd.last) begin
            run_in  = '0;
            seen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= '0;
         seen_ff <= 1'b0;
         for (int i = 0; i < MAX_GAP; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         run_ff  <= run_in;
         seen_ff <= seen_in;
         if (close_run) begin
            hist_ff[rd_idx] <= inc_count;
         end
      end
   end

   // a column whose string is not a gap always leaves the run closed
   assert property (@(posedge clock) disable iff (reset)
      cmd.en && !cmd.readout && !cmd.is_gap |=> run_ff == '0)
      else $error("run not closed by base");

   // the run never passes the top bin
   assert property (@(posedge clock) disable iff (reset)
      run_ff <= RUN_W'(MAX_GAP))
      else $error("run length beyond MAX_GAP");

   // a counted run always reports a nonzero count
   assert property (@(posedge clock) disable iff (reset)
      close_run |-> res.count != '0)
      else $error("counted run with zero count");

endmodule

@@ tb/tb_alignment_gap_length_histogram.sv @@
// Self-checking testbench for the alignment gap length histogram block.
module tb_alignment_gap_length_histogram;
   import aglh_pkg::*;

   // string index into the gap tracker arrays
   localparam int STR_REF  = 0;
   localparam int STR_READ = 1;

   localparam logic [CHAR_W-1:0] CH_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_C = 8'h43;
   localparam logic [CHAR_W-1:0] CH_G = 8'h47;
   localparam logic [CHAR_W-1:0] CH_T = 8'h54;

   localparam int ITEM_TARGET = 1950;
   localparam int QUIET_LO    = 700;   // window of items with no idling on either side
   localparam int QUIET_HI    = 1100;
   localparam int DRAIN_CYCLES = 10;   // margin after the final drain

   // one result item as seen on the response channel
   typedef struct packed {
      logic               ref_gap_done;
      logic [BIN_W-1:0]   ref_gap_bin;
      logic               read_gap_done;
      logic [BIN_W-1:0]   read_gap_bin;
      logic [COUNT_W-1:0] ref_bin_count;
      logic [COUNT_W-1:0] read_bin_count;
   } gap_result_type;

   logic clock;
   logic reset;

   aglh_req_if req_ch ();
   aglh_rsp_if rsp_ch ();

   alignment_gap_length_histogram dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // stimulus waiting to go out, and results still owed by the block
   req_item_type   pending_items[$];
   gap_result_type gap_expect[$];

   // predictor state: one gap tracker per string
   logic [RUN_W-1:0]   run_len   [2];
   logic               seen_base [2];
   logic [COUNT_W-1:0] gap_hist  [2][MAX_GAP];

   int error_count;
   int pushed_count;
   int sent_count;
   int result_count;
   int column_count;
   int readout_count;
   int reads_ended;
   int runs_counted;
   int top_bin_hits;

   // clock: period 8
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor: advances the tracker copy by one accepted item and
   // returns the result item the block owes for it.
   // ------------------------------------------------------------------
   function automatic gap_result_type predict_gap_result(req_item_type it);
      gap_result_type     r;
      logic [CHAR_W-1:0]  ch;
      logic               done;
      logic [BIN_W-1:0]   b;
      logic [COUNT_W-1:0] cnt;
      r = '0;
      if (it.func == FUNC_READOUT) begin
         // readout leaves state alone; bins past the top read as zero
         readout_count++;
         if (it.bin_select < MAX_GAP) begin
            r.ref_bin_count  = gap_hist[STR_REF][it.bin_select];
            r.read_bin_count = gap_hist[STR_READ][it.bin_select];
         end
      end else begin
         column_count++;
         for (int s = 0; s < 2; s++) begin
            ch   = (s == STR_REF) ? it.ref_char : it.read_char;
            done = 1'b0;
            b    = '0;
            cnt  = '0;
            if (ch == GAP_CHAR) begin
               // run length sticks at the top bin
               if (run_len[s] < MAX_GAP) run_len[s]++;
            end else begin
               // a base closes the run; only interior runs are counted
               if (run_len[s] != 0 && seen_base[s]) begin
                  b = run_len[s] - 1'b1;
                  if (gap_hist[s][b] != '1) gap_hist[s][b]++;
                  done = 1'b1;
                  cnt  = gap_hist[s][b];
                  runs_counted++;
                  if (b == MAX_GAP - 1) top_bin_hits++;
               end
               seen_base[s] = 1'b1;
               run_len[s]   = '0;
            end
            if (s == STR_REF) begin
               r.ref_gap_done  = done;
               r.ref_gap_bin   = b;
               r.ref_bin_count = cnt;
            end else begin
               r.read_gap_done  = done;
               r.read_gap_bin   = b;
               r.read_bin_count = cnt;
            end
         end
         // end of read: an open run is dropped, next read starts fresh
         if (it.last_column) begin
            reads_ended++;
            for (int s = 0; s < 2; s++) begin
               run_len[s]   = '0;
               seen_base[s] = 1'b0;
            end
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_item(req_item_type it);
      pending_items.push_back(it);
      pushed_count++;
   endtask

   task automatic push_column(logic [CHAR_W-1:0] rc, logic [CHAR_W-1:0] dc, logic last);
      req_item_type it;
      it.func        = FUNC_COLUMN;
      it.ref_char    = rc;
      it.read_char   = dc;
      it.last_column = last;
      it.bin_select  = BIN_W'($urandom_range(0, 15));   // ignored on columns
      push_item(it);
   endtask

   // readout with junk in the ignored fields
   task automatic push_readout(logic [BIN_W-1:0] sel);
      req_item_type it;
      it.func        = FUNC_READOUT;
      it.ref_char    = CHAR_W'($urandom_range(0, 255));
      it.read_char   = CHAR_W'($urandom_range(0, 255));
      it.last_column = 1'($urandom_range(0, 1));
      it.bin_select  = sel;
      push_item(it);
   endtask

   function automatic logic [CHAR_W-1:0] pick_base();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) begin
         case (r % 4)
            0: return CH_A;
            1: return CH_C;
            2: return CH_G;
            default: return CH_T;
         endcase
      end else if (r == 19) begin
         return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      end
      return CHAR_W'($urandom_range(0, 255));   // may land on '-' now and then
   endfunction

   // mostly short runs, some past the top bin
   function automatic int pick_run_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
      return $urandom_range(5, 15);
   endfunction

   // one well-formed read, readouts sprinkled in
   task automatic push_random_read();
      int                n_cols;
      int                gap_left [2];
      logic [CHAR_W-1:0] ch [2];
      n_cols = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 20);
      for (int s = 0; s < 2; s++)
         gap_left[s] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      for (int c = 0; c < n_cols; c++) begin
         if ($urandom_range(0, 11) == 0) push_readout(BIN_W'($urandom_range(0, 15)));
         for (int s = 0; s < 2; s++) begin
            if (gap_left[s] > 0) begin
               ch[s] = GAP_CHAR;
               gap_left[s]--;
            end else begin
               ch[s] = pick_base();
               if ($urandom_range(0, 2) == 0) gap_left[s] = pick_run_len();
            end
         end
         push_column(ch[STR_REF], ch[STR_READ], c == n_cols - 1);
      end
   endtask

   // broken sequences: raw bytes, random flags and functions
   task automatic push_noise();
      req_item_type it;
      int           n;
      n = $urandom_range(1, 8);
      for (int k = 0; k < n; k++) begin
         it.func        = ($urandom_range(0, 4) == 0) ? FUNC_READOUT : FUNC_COLUMN;
         it.ref_char    = ($urandom_range(0, 1) != 0) ? GAP_CHAR : 8'($urandom_range(0, 255));
         it.read_char   = ($urandom_range(0, 1) != 0) ? GAP_CHAR : 8'($urandom_range(0, 255));
         it.last_column = ($urandom_range(0, 3) == 0);
         it.bin_select  = BIN_W'($urandom_range(0, 15));
         push_item(it);
      end
   endtask

   task automatic push_random_until(int target);
      while (pushed_count < target) begin
         if ($urandom_range(0, 9) == 0) push_noise();
         else push_random_read();
      end
   endtask

   // wait until everything queued has gone out and come back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_ch.valid || gap_expect.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [COUNT_W-1:0] got,
                                  logic [COUNT_W-1:0] want);
      error_count++;
      $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
               result_count, what, got, want);
   endtask

   task automatic check_field(string what, logic [COUNT_W-1:0] got,
                              logic [COUNT_W-1:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // ------------------------------------------------------------------
   // Driver: presents items from the pending queue, idles ~10% of cycles
   // outside the quiet window. Accepted items feed the predictor here.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_proc
      req_item_type nxt;
      logic         launch;
      logic         idle;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            nxt.func        = req_ch.func;
            nxt.ref_char    = req_ch.ref_char;
            nxt.read_char   = req_ch.read_char;
            nxt.last_column = req_ch.last_column;
            nxt.bin_select  = req_ch.bin_select;
            gap_expect.push_back(predict_gap_result(nxt));
            sent_count++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            idle   = !(sent_count >= QUIET_LO && sent_count < QUIET_HI)
                     && ($urandom_range(0, 99) < 10);
            launch = 1'b0;
            if (pending_items.size() != 0 && !idle) begin
               nxt    = pending_items.pop_front();
               launch = 1'b1;
            end
            req_ch.valid <= launch;
            if (launch) begin
               req_ch.func        <= nxt.func;
               req_ch.ref_char    <= nxt.ref_char;
               req_ch.read_char   <= nxt.read_char;
               req_ch.last_column <= nxt.last_column;
               req_ch.bin_select  <= nxt.bin_select;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compares each accepted result with the oldest expectation,
   // stalls ~10% of cycles outside the quiet window.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : sink_proc
      gap_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            result_count++;
            if (gap_expect.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_ch.ref_bin_count, '0);
            end else begin
               want = gap_expect.pop_front();
               check_field("ref_gap_done", COUNT_W'(rsp_ch.ref_gap_done),
                           COUNT_W'(want.ref_gap_done));
               check_field("ref_gap_bin", COUNT_W'(rsp_ch.ref_gap_bin),
                           COUNT_W'(want.ref_gap_bin));
               check_field("read_gap_done", COUNT_W'(rsp_ch.read_gap_done),
                           COUNT_W'(want.read_gap_done));
               check_field("read_gap_bin", COUNT_W'(rsp_ch.read_gap_bin),
                           COUNT_W'(want.read_gap_bin));
               check_field("ref_bin_count", rsp_ch.ref_bin_count, want.ref_bin_count);
               check_field("read_bin_count", rsp_ch.read_bin_count, want.read_bin_count);
            end
         end
         rsp_ch.ready <= (result_count >= QUIET_LO && result_count < QUIET_HI)
                         || ($urandom_range(0, 99) >= 10);
      end
   end

   // ------------------------------------------------------------------
   // Sequence: reset, directed columns and readouts, random reads in two
   // halves with a full drain in between, then the final drain.
   // ------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.func        = FUNC_COLUMN;
      req_ch.ref_char    = '0;
      req_ch.read_char   = '0;
      req_ch.last_column = 1'b0;
      req_ch.bin_select  = '0;
      rsp_ch.ready       = 1'b0;
      error_count   = 0;
      pushed_count  = 0;
      sent_count    = 0;
      result_count  = 0;
      column_count  = 0;
      readout_count = 0;
      reads_ended   = 0;
      runs_counted  = 0;
      top_bin_hits  = 0;
      for (int s = 0; s < 2; s++) begin
         run_len[s]   = '0;
         seen_base[s] = 1'b0;
         for (int b = 0; b < MAX_GAP; b++) gap_hist[s][b] = '0;
      end

      // directed: leading ref run dropped, read run of 2 and ref run of 1 counted
      push_column(GAP_CHAR, CH_A, 1'b0);
      push_column(GAP_CHAR, CH_C, 1'b0);
      push_column(CH_G, GAP_CHAR, 1'b0);
      push_column(CH_T, GAP_CHAR, 1'b0);
      push_column(GAP_CHAR, CH_A, 1'b0);
      push_column(CH_A, CH_G, 1'b0);
      // long run on both strings, past the top bin
      for (int k = 0; k < MAX_GAP + 1; k++) push_column(GAP_CHAR, GAP_CHAR, 1'b0);
      push_column(8'h00, 8'hFF, 1'b0);
      // base on the last column still closes the ref run
      push_column(GAP_CHAR, CH_A, 1'b0);
      push_column(CH_C, CH_T, 1'b1);
      // a read that is one gap column: trailing run dropped
      push_column(GAP_CHAR, GAP_CHAR, 1'b1);
      // readouts: low bin, top bin, first bin past the top, last code
      push_readout(4'd0);
      push_readout(BIN_W'(MAX_GAP - 1));
      push_readout(BIN_W'(MAX_GAP));
      push_readout(4'd15);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      wait_drained();

      // first random half, then hold off until every result is back
      push_random_until(ITEM_TARGET / 2);
      wait_drained();
      push_random_until(ITEM_TARGET);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d columns and %0d readouts over %0d reads.",
               column_count, readout_count, reads_ended);
      $display("Counted %0d interior gap runs, %0d in the top bin; %0d results checked.",
               runs_counted, top_bin_hits, result_count);
      if (error_count == 0) begin
         $display("tb_alignment_gap_length_histogram passed");
      end else begin
         $display("tb_alignment_gap_length_histogram failed");
      end
      $finish;
   end

   // hard limit, far above the slowest correct run
   initial begin
      #(8 * 200000);
      $display("tb_alignment_gap_length_histogram failed");
      $finish;
   end

endmodule

@@ alignment_gap_length_histogram.f @@
rtl/aglh_pkg.sv
rtl/aglh_req_if.sv
rtl/aglh_rsp_if.sv
rtl/aglh_gap_track.sv
rtl/alignment_gap_length_histogram.sv
tb/tb_alignment_gap_length_histogram.sv
